[rtl/assert_macros.svh]
// assertion macros for the rtl, included by calendar_date_stepper_core.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed: prop");

// implication checked at every clock edge outside reset
`define ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed: pre implies post");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed: pre then post");

`endif

[rtl/cds_pkg.sv]
// types and constants of the calendar date stepper
`default_nettype none

package cds_pkg;

   // operation selector
   localparam logic OP_NEXT = 1'b0;
   localparam logic OP_PREV = 1'b1;

   // status codes
   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_BAD_DATE   = 2'd1;
   localparam logic [1:0] STAT_YEAR_RANGE = 2'd2;

   // calendar constants
   localparam logic [13:0] YEAR_MAX  = 14'd9999;
   localparam logic [13:0] YEAR_MIN  = 14'd0;
   localparam logic [3:0]  MONTH_JAN = 4'd1;
   localparam logic [3:0]  MONTH_FEB = 4'd2;
   localparam logic [3:0]  MONTH_MAR = 4'd3;
   localparam logic [3:0]  MONTH_APR = 4'd4;
   localparam logic [3:0]  MONTH_MAY = 4'd5;
   localparam logic [3:0]  MONTH_JUN = 4'd6;
   localparam logic [3:0]  MONTH_JUL = 4'd7;
   localparam logic [3:0]  MONTH_SEP = 4'd9;
   localparam logic [3:0]  MONTH_OCT = 4'd10;
   localparam logic [3:0]  MONTH_NOV = 4'd11;
   localparam logic [3:0]  MONTH_DEC = 4'd12;
   localparam logic [4:0]  DAY_FIRST = 5'd1;
   localparam logic [4:0]  DAYS_31   = 5'd31;
   localparam logic [4:0]  DAYS_30   = 5'd30;
   localparam logic [4:0]  DAYS_29   = 5'd29;
   localparam logic [4:0]  DAYS_28   = 5'd28;

   // year / 25 as (year * RECIP_25) >> RECIP_SHIFT, exact for year < 43690
   localparam int          RECIP_SHIFT = 19;
   localparam int          PROD_W      = 29;
   localparam int          QUOT_W      = 10;
   localparam logic [14:0] RECIP_25    = 15'd20972;

   // stage one payload: decoded month classes and year / 25 product bits
   typedef struct packed {
      logic              op;
      logic [4:0]        day;
      logic [3:0]        month;
      logic [13:0]       year;
      logic [QUOT_W-1:0] quot25;
      logic              month_ok;
      logic              year_ok;
      logic              is_feb;
      logic              len30;
      logic              prev_feb;
      logic              prev_len30;
   } dec_type;

   // stage two payload: validity and month lengths
   typedef struct packed {
      logic        op;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic        valid;
      logic [4:0]  mlen;
      logic [4:0]  prev_len;
   } chk_type;

   // result item
   typedef struct packed {
      logic [4:0]  out_day;
      logic [3:0]  out_month;
      logic [13:0] out_year;
      logic [1:0]  status;
   } res_type;

endpackage

`default_nettype wire

[rtl/cds_decode.sv]
// stage one: month decode, range checks and year / 25 reciprocal product
`default_nettype none

module cds_decode import cds_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic        in_op,
   input  wire logic [4:0]  in_day,
   input  wire logic [3:0]  in_month,
   input  wire logic [13:0] in_year,
   output logic             out_valid,
   input  wire logic        out_ready,
   output dec_type          out_data
);

   logic              valid_ff;
   logic              valid_in;
   dec_type           data_ff;
   dec_type           data_in;
   logic [PROD_W-1:0] prod;

   // stage accepts when empty or when its content moves on
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // reciprocal multiply for the divisible-by-25 test
   assign prod = PROD_W'(in_year) * PROD_W'(RECIP_25);

   // payload fields, range checks and month classes
   always_comb begin
      data_in            = '0;
      data_in.op         = in_op;
      data_in.day        = in_day;
      data_in.month      = in_month;
      data_in.year       = in_year;
      data_in.quot25     = prod[RECIP_SHIFT +: QUOT_W];
      data_in.month_ok   = (in_month >= MONTH_JAN) && (in_month <= MONTH_DEC);
      data_in.year_ok    = (in_year <= YEAR_MAX);
      data_in.is_feb     = (in_month == MONTH_FEB);
      data_in.prev_feb   = (in_month == MONTH_MAR);
      case (in_month)
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: data_in.len30 = 1'b1;
         default:                                    data_in.len30 = 1'b0;
      endcase
      case (in_month)
         MONTH_MAY, MONTH_JUL, MONTH_OCT, MONTH_DEC: data_in.prev_len30 = 1'b1;
         default:                                    data_in.prev_len30 = 1'b0;
      endcase
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[rtl/cds_check.sv]
// stage two: leap year, month lengths and date validity
`default_nettype none

module cds_check import cds_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire dec_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output chk_type      out_data
);

   logic        valid_ff;
   logic        valid_in;
   chk_type     data_ff;
   chk_type     data_in;
   logic [14:0] q_wide;
   logic [14:0] times25;
   logic        div25;
   logic        div4;
   logic        div16;
   logic        leap;
   logic [4:0]  feb_len;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // quotient times 25 by shift and add, equal to year exactly when divisible
   assign q_wide  = 15'(in_data.quot25);
   assign times25 = (q_wide << 4) + (q_wide << 3) + q_wide;
   assign div25   = (times25 == {1'b0, in_data.year});
   assign div4    = (in_data.year[1:0] == 2'd0);
   assign div16   = (in_data.year[3:0] == 4'd0);

   // full 4 / 100 / 400 rule
   assign leap    = (div4 && !div25) || (div16 && div25);
   assign feb_len = leap ? DAYS_29 : DAYS_28;

   // month lengths and validity
   always_comb begin
      data_in       = '0;
      data_in.op    = in_data.op;
      data_in.day   = in_data.day;
      data_in.month = in_data.month;
      data_in.year  = in_data.year;
      if (in_data.is_feb) begin
         data_in.mlen = feb_len;
      end else if (in_data.len30) begin
         data_in.mlen = DAYS_30;
      end else begin
         data_in.mlen = DAYS_31;
      end
      if (in_data.prev_feb) begin
         data_in.prev_len = feb_len;
      end else if (in_data.prev_len30) begin
         data_in.prev_len = DAYS_30;
      end else begin
         data_in.prev_len = DAYS_31;
      end
      data_in.valid = in_data.month_ok && in_data.year_ok &&
                      (in_data.day >= DAY_FIRST) && (in_data.day <= data_in.mlen);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[rtl/cds_step.sv]
// stage three: day, month and year carries into the result register
`default_nettype none

module cds_step import cds_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire chk_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output res_type      out_data
);

   logic    valid_ff;
   logic    valid_in;
   res_type data_ff;
   res_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // neighbor date, echo of the input on any error
   always_comb begin
      data_in.out_day   = in_data.day;
      data_in.out_month = in_data.month;
      data_in.out_year  = in_data.year;
      data_in.status    = STAT_OK;
      if (!in_data.valid) begin
         data_in.status = STAT_BAD_DATE;
      end else if (in_data.op == OP_NEXT) begin
         if (in_data.day < in_data.mlen) begin
            data_in.out_day = in_data.day + 5'd1;
         end else if (in_data.month < MONTH_DEC) begin
            data_in.out_day   = DAY_FIRST;
            data_in.out_month = in_data.month + 4'd1;
         end else if (in_data.year < YEAR_MAX) begin
            data_in.out_day   = DAY_FIRST;
            data_in.out_month = MONTH_JAN;
            data_in.out_year  = in_data.year + 14'd1;
         end else begin
            data_in.status = STAT_YEAR_RANGE;
         end
      end else begin
         if (in_data.day > DAY_FIRST) begin
            data_in.out_day = in_data.day - 5'd1;
         end else if (in_data.month > MONTH_JAN) begin
            data_in.out_day   = in_data.prev_len;
            data_in.out_month = in_data.month - 4'd1;
         end else if (in_data.year > YEAR_MIN) begin
            data_in.out_day   = DAYS_31;
            data_in.out_month = MONTH_DEC;
            data_in.out_year  = in_data.year - 14'd1;
         end else begin
            data_in.status = STAT_YEAR_RANGE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[rtl/calendar_date_stepper_core.sv]
// Pipeline: a request passes the decode, check and step stage registers in that order, and
// rsp_tvalid rises when it reaches the step stage. Throughput: one date per cycle unless
// rsp_tready stalls; each stage takes a new item when empty or moving on.
// A result waiting on rsp_tready holds the last stage; earlier empty stages still fill.
// Reset: synchronous, active high; clears the valid bit of every stage, no results pending.
`default_nettype none
`include "assert_macros.svh"

module calendar_date_stepper_core import cds_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // in_day[4:0], in_month[8:5], in_year[22:9], zero[23]
   input  wire logic        req_tuser,  // op[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // out_day[4:0], out_month[8:5], out_year[22:9], zero[23]
   output logic [1:0]       rsp_tuser   // status[1:0]
);

   logic    dec_valid;
   logic    dec_ready;
   dec_type dec_data;
   logic    chk_valid;
   logic    chk_ready;
   chk_type chk_data;
   res_type res_data;

   // stage one
   cds_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser),
      .in_day    (req_tdata[4:0]),
      .in_month  (req_tdata[8:5]),
      .in_year   (req_tdata[22:9]),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   // stage two
   cds_check u_check (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (chk_valid),
      .out_ready (chk_ready),
      .out_data  (chk_data)
   );

   // stage three, result register
   cds_step u_step (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chk_valid),
      .in_ready  (chk_ready),
      .in_data   (chk_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res_data)
   );

   // result packing
   assign rsp_tdata = {1'b0, res_data.out_year, res_data.out_month, res_data.out_day};
   assign rsp_tuser = res_data.status;

   // a good result is a real date
   `ASSERT_IMPLY(a_ok_date, rsp_tvalid && (rsp_tuser == STAT_OK),
      (rsp_tdata[8:5] >= MONTH_JAN) && (rsp_tdata[8:5] <= MONTH_DEC) &&
      (rsp_tdata[4:0] >= DAY_FIRST) && (rsp_tdata[22:9] <= YEAR_MAX))
   // status is always one of the defined codes
   `ASSERT_IMPLY(a_status_code, rsp_tvalid,
      (rsp_tuser == STAT_OK) || (rsp_tuser == STAT_BAD_DATE) ||
      (rsp_tuser == STAT_YEAR_RANGE))
   // a year overflow only happens at the two ends of the range
   `ASSERT_IMPLY(a_range_ends, rsp_tvalid && (rsp_tuser == STAT_YEAR_RANGE),
      ((rsp_tdata[22:9] == YEAR_MAX) && (rsp_tdata[8:5] == MONTH_DEC) &&
       (rsp_tdata[4:0] == DAYS_31)) ||
      ((rsp_tdata[22:9] == YEAR_MIN) && (rsp_tdata[8:5] == MONTH_JAN) &&
       (rsp_tdata[4:0] == DAY_FIRST)))
   // a stalled middle stage keeps its item
   `ASSERT_NEXT(a_chk_hold, chk_valid && !chk_ready, chk_valid && $stable(chk_data))

endmodule

`default_nettype wire
